// ----- design/ncu_pkg.sv -----
// Shared types, codes and helpers for the network coordinate update block.
// No dependencies; imported by every module of the block.
package ncu_pkg;

	// Operand and result widths of the shared iterative unit
	localparam int unsigned OPA_W = 68;
	localparam int unsigned OPB_W = 40;
	localparam int unsigned RES_W = 80;
	localparam int unsigned DIV_BITS = 52;
	localparam int unsigned SQRT_PAIRS = 34;

	// Shared unit operations
	typedef logic [1:0] ncu_op_t;
	localparam ncu_op_t OP_MUL  = 2'd0;
	localparam ncu_op_t OP_DIV  = 2'd1;
	localparam ncu_op_t OP_SQRT = 2'd2;

	// Request from the sequencer to the shared unit
	typedef struct packed {
		logic    start;
		ncu_op_t op;
	} ncu_req_t;

	// Result status codes
	typedef logic [1:0] ncu_status_t;
	localparam ncu_status_t STATUS_OK     = 2'd0;
	localparam ncu_status_t STATUS_RANGE  = 2'd1;
	localparam ncu_status_t STATUS_RTT    = 2'd2;
	localparam ncu_status_t STATUS_ERRSUM = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_COORD_GAIN     = 3'd0;
	localparam logic [2:0] CFG_ERROR_GAIN     = 3'd1;
	localparam logic [2:0] CFG_ERROR_FLOOR    = 3'd2;
	localparam logic [2:0] CFG_INITIAL_ERROR  = 3'd3;
	localparam logic [2:0] CFG_CONVERGE_EVERY = 3'd4;
	localparam logic [2:0] CFG_CONVERGE_ERROR = 3'd5;
	localparam logic [2:0] CFG_MAX_COORDINATE = 3'd6;
	localparam logic [2:0] CFG_MAX_RTT        = 3'd7;

	// RTT of the convergence pass: 10 ms in Q20.12
	localparam logic [31:0] CONV_RTT = 32'd40960;

	// floor(v / 10) for a 16-bit value by reciprocal multiply
	function automatic logic [12:0] div10(input logic [15:0] v);
		logic [35:0] p;
		p = {20'd0, v} * 36'd52429;
		return p[31:19];
	endfunction

	// magnitude of a 32-bit signed value
	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

// ----- design/ncu_seq_unit.sv -----
// Shared iterative arithmetic unit: shift-add multiply, restoring divide,
// bit-pair square root. Depends on ncu_pkg.
module ncu_seq_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ncu_pkg::ncu_req_t         req,
	input  logic [ncu_pkg::OPA_W-1:0] opa,
	input  logic [ncu_pkg::OPB_W-1:0] opb,
	output logic                      done,
	output logic [ncu_pkg::RES_W-1:0] res
);
	import ncu_pkg::*;

	logic               busy_q;
	logic               done_q;
	ncu_op_t            op_q;
	logic [5:0]         cnt_q;
	logic [RES_W-1:0]   a_q;
	logic [OPB_W-1:0]   b_q;
	logic [OPB_W-1:0]   rem_q;
	logic [RES_W-1:0]   acc_q;

	logic [OPB_W-1:0]   div_trial;
	logic               div_ge;
	logic [OPB_W-1:0]   sq_trial;
	logic [OPB_W-1:0]   sq_test;
	logic               sq_ge;
	logic               last;

	// trial subtracts for divide and square root
	always_comb begin
		div_trial = {rem_q[OPB_W-2:0], a_q[RES_W-1]};
		div_ge    = div_trial >= b_q;
		sq_trial  = {rem_q[OPB_W-3:0], a_q[RES_W-1:RES_W-2]};
		sq_test   = {acc_q[OPB_W-3:0], 2'b01};
		sq_ge     = sq_trial >= sq_test;
		case (op_q)
			OP_MUL:  last = (b_q == '0);
			default: last = (cnt_q == '0);
		endcase
	end

	// control: busy, iteration count, completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				case (req.op)
					OP_DIV:  cnt_q <= 6'(DIV_BITS);
					OP_SQRT: cnt_q <= 6'(SQRT_PAIRS);
					default: cnt_q <= '0;
				endcase
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (op_q != OP_MUL) begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// datapath: one step per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			rem_q <= '0;
			b_q   <= opb;
			case (req.op)
				OP_DIV:  a_q <= {opa[DIV_BITS-1:0], (RES_W-DIV_BITS)'(0)};
				OP_SQRT: a_q <= {opa, (RES_W-OPA_W)'(0)};
				default: a_q <= RES_W'(opa);
			endcase
		end else if (busy_q && !last) begin
			case (op_q)
				OP_MUL: begin
					if (b_q[0])
						acc_q <= acc_q + a_q;
					a_q <= {a_q[RES_W-2:0], 1'b0};
					b_q <= {1'b0, b_q[OPB_W-1:1]};
				end
				OP_DIV: begin
					rem_q <= div_ge ? (div_trial - b_q) : div_trial;
					acc_q <= {acc_q[RES_W-2:0], div_ge};
					a_q   <= {a_q[RES_W-2:0], 1'b0};
				end
				OP_SQRT: begin
					rem_q <= sq_ge ? (sq_trial - sq_test) : sq_trial;
					acc_q <= {acc_q[RES_W-2:0], sq_ge};
					a_q   <= {a_q[RES_W-3:0], 2'b00};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = acc_q;

endmodule

// ----- design/network_coordinate_update.sv -----
// Network coordinate update top level: config registers, pass sequencer and
// the local coordinate state. Depends on ncu_pkg and ncu_seq_unit.
// A pass runs its multiplies, divides and square roots in turn on the one shared unit; a
// rejected pass uses no unit step, and a due convergence pass adds a second pass to the item.
// One request is taken at a time; in_stall is high from accept until the result is
// loaded into the output register. Reset loads defaults.
module network_coordinate_update (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  remote_x,
	input  logic signed [31:0]  remote_y,
	input  logic signed [31:0]  remote_h,
	input  logic [31:0]         remote_err,
	input  logic [31:0]         rtt,
	input  logic [15:0]         jitter_x,
	input  logic [15:0]         jitter_y,
	input  logic [15:0]         dir_x,
	input  logic [15:0]         dir_y,
	input  logic [15:0]         dir_h,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic signed [31:0]  local_x_out,
	output logic signed [31:0]  local_y_out,
	output logic signed [31:0]  local_h_out,
	output logic [31:0]         local_err_out,
	output logic                fell_back,
	output logic                converged
);
	import ncu_pkg::*;

	// sequencer states
	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_CHECK   = 5'd1;
	localparam logic [4:0] ST_DX2     = 5'd2;
	localparam logic [4:0] ST_DY2     = 5'd3;
	localparam logic [4:0] ST_DIST    = 5'd4;
	localparam logic [4:0] ST_W       = 5'd5;
	localparam logic [4:0] ST_ES      = 5'd6;
	localparam logic [4:0] ST_CW      = 5'd7;
	localparam logic [4:0] ST_NE1     = 5'd8;
	localparam logic [4:0] ST_NE2     = 5'd9;
	localparam logic [4:0] ST_DELTA   = 5'd10;
	localparam logic [4:0] ST_SC      = 5'd11;
	localparam logic [4:0] ST_VEC     = 5'd12;
	localparam logic [4:0] ST_VX2     = 5'd13;
	localparam logic [4:0] ST_VY2     = 5'd14;
	localparam logic [4:0] ST_MAG     = 5'd15;
	localparam logic [4:0] ST_UX      = 5'd16;
	localparam logic [4:0] ST_MX      = 5'd17;
	localparam logic [4:0] ST_UY      = 5'd18;
	localparam logic [4:0] ST_MY      = 5'd19;
	localparam logic [4:0] ST_UH      = 5'd20;
	localparam logic [4:0] ST_MH      = 5'd21;
	localparam logic [4:0] ST_APPLY   = 5'd22;
	localparam logic [4:0] ST_PASSEND = 5'd23;
	localparam logic [4:0] ST_OUT     = 5'd24;

	// configuration
	logic [15:0] coord_gain_q;
	logic [15:0] error_gain_q;
	logic [31:0] error_floor_q;
	logic [31:0] initial_error_q;
	logic [7:0]  converge_every_q;
	logic [31:0] converge_error_q;
	logic [30:0] max_coordinate_q;
	logic [31:0] max_rtt_q;

	// local state
	logic [31:0] loc_x_q, loc_y_q, loc_h_q, loc_err_q;
	logic [7:0]  upd_cnt_q;

	// per-request and per-pass registers
	logic [4:0]  state_q;
	logic        iss_q;
	logic [31:0] prx_q, pry_q, prh_q, prerr_q, prtt_q;
	logic [12:0] jx10_q, jy10_q;
	logic [15:0] dir_x_q, dir_y_q, dir_h_q;
	logic        fb_q, conv_q, fbk_q, dir_used_q;
	ncu_status_t pst_q;

	// working values
	logic [67:0] sqa_q;
	logic [35:0] dist_q;
	logic [32:0] sum_q;
	logic [16:0] w_q;
	logic [35:0] are_q;
	logic        neg_q;
	logic [31:0] es_q;
	logic [15:0] cw_q;
	logic [47:0] nacc_q;
	logic [31:0] ne_q;
	logic [15:0] delta_q;
	logic [35:0] sc_q;
	logic [34:0] vx_q, vy_q;
	logic [33:0] vh_q;
	logic [35:0] mag_q;
	logic [16:0] u_q;
	logic [38:0] nx_q, ny_q, nh_q;

	// output register
	logic        out_valid_q;
	ncu_status_t status_q;
	logic [31:0] ox_q, oy_q, oh_q, oerr_q;
	logic        ofb_q, oconv_q;

	// shared unit
	ncu_req_t           u_req;
	logic [OPA_W-1:0]   u_opa;
	logic [OPB_W-1:0]   u_opb;
	logic               u_done;
	logic [RES_W-1:0]   u_res;
	logic               op_state;

	// combinational helpers
	logic [31:0] mc32;
	logic        rng_bad, rtt_bad;
	logic [32:0] err_sum;
	logic [32:0] dx, dy, dxm, dym;
	logic [32:0] phr, hm;
	logic [35:0] rt16;
	logic [36:0] re;
	logic [34:0] vxm, vym;
	logic [33:0] vh_sum;
	logic [49:0] nsum;
	logic [36:0] move;
	logic [38:0] px39, py39, ph39, nt;
	logic [38:0] nxm, nym;
	logic        new_ok;
	logic [8:0]  cnt9;

	always_comb begin
		mc32    = {1'b0, max_coordinate_q};
		rng_bad = (mag32(loc_x_q) > mc32) || (mag32(loc_y_q) > mc32) ||
			(mag32(loc_h_q) > mc32) || (mag32(prx_q) > mc32) ||
			(mag32(pry_q) > mc32) || (mag32(prh_q) > mc32);
		rtt_bad = (prtt_q == '0) || (prtt_q > max_rtt_q);
		err_sum = {1'b0, loc_err_q} + {1'b0, prerr_q};
		// direct distance terms
		dx  = {loc_x_q[31], loc_x_q} - {prx_q[31], prx_q};
		dy  = {loc_y_q[31], loc_y_q} - {pry_q[31], pry_q};
		dxm = dx[32] ? (~dx + 33'd1) : dx;
		dym = dy[32] ? (~dy + 33'd1) : dy;
		phr = {loc_h_q[31], loc_h_q} + {prh_q[31], prh_q};
		hm  = phr[32] ? (~phr + 33'd1) : phr;
		rt16 = {prtt_q, 4'd0};
		re   = {1'b0, rt16} - {1'b0, dist_q};
		// direction vector terms
		vxm    = vx_q[34] ? (~vx_q + 35'd1) : vx_q;
		vym    = vy_q[34] ? (~vy_q + 35'd1) : vy_q;
		vh_sum = {{2{loc_h_q[31]}}, loc_h_q} + {2'b00, mag32(prh_q)};
		nsum   = {2'b00, nacc_q} + u_res[49:0];
		move   = u_res[52:16];
		px39   = {{7{loc_x_q[31]}}, loc_x_q};
		py39   = {{7{loc_y_q[31]}}, loc_y_q};
		ph39   = {{7{loc_h_q[31]}}, loc_h_q};
		nt     = neg_q ? (ph39 - {2'b00, move}) : (ph39 + {2'b00, move});
		nxm    = nx_q[38] ? (~nx_q + 39'd1) : nx_q;
		nym    = ny_q[38] ? (~ny_q + 39'd1) : ny_q;
		new_ok = !fbk_q && (nxm <= 39'(mc32)) && (nym <= 39'(mc32)) &&
			(nh_q <= 39'(mc32));
		cnt9   = {1'b0, upd_cnt_q} + {8'd0, (prx_q != '0) || (pry_q != '0)};
	end

	// operand selection per sequencer step
	always_comb begin
		op_state = 1'b1;
		u_req.op = OP_MUL;
		u_opa    = '0;
		u_opb    = '0;
		case (state_q)
			ST_DX2: begin
				u_opa = OPA_W'(dxm);
				u_opb = OPB_W'(dxm);
			end
			ST_DY2: begin
				u_opa = OPA_W'(dym);
				u_opb = OPB_W'(dym);
			end
			ST_DIST: begin
				u_req.op = OP_SQRT;
				u_opa    = sqa_q;
			end
			ST_W: begin
				u_req.op = OP_DIV;
				u_opa    = OPA_W'({loc_err_q, 16'd0});
				u_opb    = OPB_W'(sum_q);
			end
			ST_ES: begin
				u_req.op = OP_DIV;
				u_opa    = OPA_W'({are_q, 16'd0});
				u_opb    = OPB_W'(rt16);
			end
			ST_CW: begin
				u_opa = OPA_W'(error_gain_q);
				u_opb = OPB_W'(w_q);
			end
			ST_NE1: begin
				u_opa = OPA_W'(es_q);
				u_opb = OPB_W'(cw_q);
			end
			ST_NE2: begin
				u_opa = OPA_W'(loc_err_q);
				u_opb = OPB_W'(17'h10000 - {1'b0, cw_q});
			end
			ST_DELTA: begin
				u_opa = OPA_W'(coord_gain_q);
				u_opb = OPB_W'(w_q);
			end
			ST_SC: begin
				u_opa = OPA_W'(are_q);
				u_opb = OPB_W'(delta_q);
			end
			ST_VX2: begin
				u_opa = OPA_W'(vxm);
				u_opb = OPB_W'(vxm);
			end
			ST_VY2: begin
				u_opa = OPA_W'(vym);
				u_opb = OPB_W'(vym);
			end
			ST_MAG: begin
				u_req.op = OP_SQRT;
				u_opa    = sqa_q;
			end
			ST_UX: begin
				u_req.op = OP_DIV;
				u_opa    = OPA_W'({vxm, 16'd0});
				u_opb    = OPB_W'(mag_q);
			end
			ST_UY: begin
				u_req.op = OP_DIV;
				u_opa    = OPA_W'({vym, 16'd0});
				u_opb    = OPB_W'(mag_q);
			end
			ST_UH: begin
				u_req.op = OP_DIV;
				u_opa    = OPA_W'({vh_q, 16'd0});
				u_opb    = OPB_W'(mag_q);
			end
			ST_MX, ST_MY, ST_MH: begin
				u_opa = OPA_W'(sc_q);
				u_opb = OPB_W'(u_q);
			end
			default: begin
				op_state = 1'b0;
			end
		endcase
		u_req.start = op_state && !iss_q;
	end

	ncu_seq_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (u_req),
		.opa    (u_opa),
		.opb    (u_opb),
		.done   (u_done),
		.res    (u_res)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_gain_q     <= 16'd16384;
			error_gain_q     <= 16'd32768;
			error_floor_q    <= 32'd6554;
			initial_error_q  <= 32'd655360;
			converge_every_q <= 8'd5;
			converge_error_q <= 32'd3276800;
			max_coordinate_q <= 31'd1966080000;
			max_rtt_q        <= 32'd1228800000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COORD_GAIN:     coord_gain_q     <= cfg_data[15:0];
				CFG_ERROR_GAIN:     error_gain_q     <= cfg_data[15:0];
				CFG_ERROR_FLOOR:    error_floor_q    <= cfg_data;
				CFG_INITIAL_ERROR:  initial_error_q  <= cfg_data;
				CFG_CONVERGE_EVERY: converge_every_q <= cfg_data[7:0];
				CFG_CONVERGE_ERROR: converge_error_q <= cfg_data;
				CFG_MAX_COORDINATE: max_coordinate_q <= cfg_data[30:0];
				CFG_MAX_RTT:        max_rtt_q        <= cfg_data;
				default:            max_rtt_q        <= max_rtt_q;
			endcase
		end
	end

	// sequencer, pass datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= 1'b0;
			loc_x_q     <= '0;
			loc_y_q     <= '0;
			loc_h_q     <= '0;
			loc_err_q   <= 32'd655360;
			upd_cnt_q   <= '0;
			prx_q       <= '0;
			pry_q       <= '0;
			prh_q       <= '0;
			prerr_q     <= '0;
			prtt_q      <= '0;
			jx10_q      <= '0;
			jy10_q      <= '0;
			dir_x_q     <= '0;
			dir_y_q     <= '0;
			dir_h_q     <= '0;
			fb_q        <= 1'b0;
			conv_q      <= 1'b0;
			fbk_q       <= 1'b0;
			dir_used_q  <= 1'b0;
			pst_q       <= STATUS_OK;
			sqa_q       <= '0;
			dist_q      <= '0;
			sum_q       <= '0;
			w_q         <= '0;
			are_q       <= '0;
			neg_q       <= 1'b0;
			es_q        <= '0;
			cw_q        <= '0;
			nacc_q      <= '0;
			ne_q        <= '0;
			delta_q     <= '0;
			sc_q        <= '0;
			vx_q        <= '0;
			vy_q        <= '0;
			vh_q        <= '0;
			mag_q       <= '0;
			u_q         <= '0;
			nx_q        <= '0;
			ny_q        <= '0;
			nh_q        <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STATUS_OK;
			ox_q        <= '0;
			oy_q        <= '0;
			oh_q        <= '0;
			oerr_q      <= '0;
			ofb_q       <= 1'b0;
			oconv_q     <= 1'b0;
		end else begin
			// unit handshake
			if (u_req.start)
				iss_q <= 1'b1;
			else if (u_done)
				iss_q <= 1'b0;
			if (out_valid_q && !out_stall && (state_q != ST_OUT))
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						prx_q   <= remote_x;
						pry_q   <= remote_y;
						prh_q   <= remote_h;
						prerr_q <= remote_err;
						prtt_q  <= rtt;
						jx10_q  <= div10(jitter_x);
						jy10_q  <= div10(jitter_y);
						dir_x_q <= dir_x;
						dir_y_q <= dir_y;
						dir_h_q <= dir_h;
						fb_q    <= 1'b0;
						conv_q  <= 1'b0;
						state_q <= ST_CHECK;
					end
				end
				// range, rtt and error-sum checks
				ST_CHECK: begin
					fbk_q <= 1'b0;
					sum_q <= err_sum;
					if (rng_bad) begin
						pst_q   <= STATUS_RANGE;
						state_q <= ST_PASSEND;
					end else if (rtt_bad) begin
						pst_q   <= STATUS_RTT;
						state_q <= ST_PASSEND;
					end else if (err_sum == '0) begin
						pst_q   <= STATUS_ERRSUM;
						state_q <= ST_PASSEND;
					end else begin
						state_q <= ST_DX2;
					end
				end
				ST_DX2: if (u_done) begin
					sqa_q   <= u_res[67:0];
					state_q <= ST_DY2;
				end
				ST_DY2: if (u_done) begin
					sqa_q   <= sqa_q + u_res[67:0];
					state_q <= ST_DIST;
				end
				ST_DIST: if (u_done) begin
					dist_q  <= 36'(u_res[33:0]) + 36'(hm);
					state_q <= ST_W;
				end
				// weight; relative error taken from the registered distance
				ST_W: begin
					if (!iss_q) begin
						neg_q <= re[36];
						are_q <= re[36] ? 36'(~re + 37'd1) : re[35:0];
					end
					if (u_done) begin
						w_q     <= u_res[16:0];
						state_q <= ST_ES;
					end
				end
				ST_ES: if (u_done) begin
					es_q    <= (|u_res[51:32]) ? 32'hFFFF_FFFF : u_res[31:0];
					state_q <= ST_CW;
				end
				ST_CW: if (u_done) begin
					cw_q    <= u_res[31:16];
					state_q <= ST_NE1;
				end
				ST_NE1: if (u_done) begin
					nacc_q  <= u_res[47:0];
					state_q <= ST_NE2;
				end
				ST_NE2: if (u_done) begin
					ne_q    <= (|nsum[49:48]) ? 32'hFFFF_FFFF : nsum[47:16];
					state_q <= ST_DELTA;
				end
				ST_DELTA: if (u_done) begin
					delta_q <= u_res[31:16];
					state_q <= ST_SC;
				end
				ST_SC: if (u_done) begin
					sc_q    <= u_res[51:16];
					state_q <= ST_VEC;
				end
				// direction from the jittered remote position
				ST_VEC: begin
					vx_q <= {{3{loc_x_q[31]}}, loc_x_q} - {{3{prx_q[31]}}, prx_q} -
						{22'd0, jx10_q};
					vy_q <= {{3{loc_y_q[31]}}, loc_y_q} - {{3{pry_q[31]}}, pry_q} -
						{22'd0, jy10_q};
					vh_q <= vh_sum[33] ? (~vh_sum + 34'd1) : vh_sum;
					dir_used_q <= 1'b0;
					state_q    <= ST_VX2;
				end
				ST_VX2: if (u_done) begin
					sqa_q   <= u_res[67:0];
					state_q <= ST_VY2;
				end
				ST_VY2: if (u_done) begin
					sqa_q   <= sqa_q + u_res[67:0];
					state_q <= ST_MAG;
				end
				// zero length: retry once with the supplied direction
				ST_MAG: if (u_done) begin
					mag_q <= 36'(u_res[34:0]) + 36'(vh_q);
					if ((u_res == '0) && (vh_q == '0)) begin
						if (!dir_used_q) begin
							vx_q       <= 35'(dir_x_q);
							vy_q       <= 35'(dir_y_q);
							vh_q       <= 34'(dir_h_q);
							dir_used_q <= 1'b1;
							state_q    <= ST_VX2;
						end else begin
							fbk_q   <= 1'b1;
							state_q <= ST_APPLY;
						end
					end else begin
						state_q <= ST_UX;
					end
				end
				ST_UX: if (u_done) begin
					u_q     <= u_res[16:0];
					state_q <= ST_MX;
				end
				ST_MX: if (u_done) begin
					nx_q    <= (neg_q ^ vx_q[34]) ? (px39 - {2'b00, move}) :
						(px39 + {2'b00, move});
					state_q <= ST_UY;
				end
				ST_UY: if (u_done) begin
					u_q     <= u_res[16:0];
					state_q <= ST_MY;
				end
				ST_MY: if (u_done) begin
					ny_q    <= (neg_q ^ vy_q[34]) ? (py39 - {2'b00, move}) :
						(py39 + {2'b00, move});
					state_q <= ST_UH;
				end
				ST_UH: if (u_done) begin
					u_q     <= u_res[16:0];
					state_q <= ST_MH;
				end
				ST_MH: if (u_done) begin
					nh_q    <= nt[38] ? (~nt + 39'd1) : nt;
					state_q <= ST_APPLY;
				end
				// commit new position or fall back to the origin
				ST_APPLY: begin
					pst_q <= STATUS_OK;
					if (new_ok) begin
						loc_x_q   <= nx_q[31:0];
						loc_y_q   <= ny_q[31:0];
						loc_h_q   <= nh_q[31:0];
						loc_err_q <= (ne_q > error_floor_q) ? ne_q : error_floor_q;
					end else begin
						loc_x_q   <= '0;
						loc_y_q   <= '0;
						loc_h_q   <= '0;
						loc_err_q <= initial_error_q;
						fb_q      <= 1'b1;
					end
					state_q <= ST_PASSEND;
				end
				// update count; launch the convergence pass when due
				ST_PASSEND: begin
					if (!conv_q && (pst_q == STATUS_OK)) begin
						if (cnt9 > {1'b0, converge_every_q}) begin
							upd_cnt_q <= '0;
							conv_q    <= 1'b1;
							prx_q     <= '0;
							pry_q     <= '0;
							prh_q     <= '0;
							prerr_q   <= converge_error_q;
							prtt_q    <= CONV_RTT;
							state_q   <= ST_CHECK;
						end else begin
							upd_cnt_q <= cnt9[7:0];
							state_q   <= ST_OUT;
						end
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= pst_q;
						ox_q        <= loc_x_q;
						oy_q        <= loc_y_q;
						oh_q        <= loc_h_q;
						oerr_q      <= loc_err_q;
						ofb_q       <= fb_q;
						oconv_q     <= conv_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign local_x_out   = ox_q;
	assign local_y_out   = oy_q;
	assign local_h_out   = oh_q;
	assign local_err_out = oerr_q;
	assign fell_back     = ofb_q;
	assign converged     = oconv_q;

endmodule

// ----- design/ncu_checker.sv -----
// Port-level checks for the network coordinate update block, and the bind
// that attaches them to the top level. Depends on ncu_pkg.
module ncu_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [1:0]          status,
	input logic signed [31:0]  local_x_out,
	input logic signed [31:0]  local_y_out,
	input logic signed [31:0]  local_h_out,
	input logic [31:0]         local_err_out,
	input logic                fell_back,
	input logic                converged
);
	import ncu_pkg::*;

	// a request in work blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a request is in work");

	// a rejected first pass never reports a fallback
	a_reject_no_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !converged && (status != STATUS_OK)) |-> !fell_back)
		else $error("fallback flagged on a rejected update");

	// a fallback without a convergence pass leaves the node at the origin
	a_fallback_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fell_back && !converged) |->
		((local_x_out == '0) && (local_y_out == '0) && (local_h_out == '0) &&
		(status == STATUS_OK)))
		else $error("fallback result not at origin");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(local_err_out)))
		else $error("stalled result dropped or changed");

endmodule

bind network_coordinate_update ncu_checker u_ncu_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for network_coordinate_update: a bit-exact predictor of the
// spring update, random valid/stall pressure on both channels, and a scoreboard.
// Depends on ncu_pkg and the network_coordinate_update RTL.
module testbench;
	import ncu_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam logic [63:0] M32 = 64'hFFFF_FFFF;

	typedef struct {
		logic signed [31:0] rx, ry, rh;
		logic [31:0] rerr, rtt;
		logic [15:0] jx, jy, dx, dy, dh;
	} sample_t;

	typedef struct {
		ncu_status_t status;
		logic [31:0] x, y, h, err;
		logic        fb, conv;
	} coord_result_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_stall, out_valid;
	logic out_stall;
	logic signed [31:0] remote_x, remote_y, remote_h;
	logic [31:0] remote_err, rtt;
	logic [15:0] jitter_x, jitter_y, dir_x, dir_y, dir_h;
	logic [1:0] status;
	logic signed [31:0] local_x_out, local_y_out, local_h_out;
	logic [31:0] local_err_out;
	logic fell_back, converged;

	// Predictor copy of configuration and local state
	logic [63:0] k_cgain, k_egain, k_floor, k_init, k_every, k_cerr, k_maxc, k_maxrtt;
	logic [31:0] cur_x, cur_y, cur_h, cur_err;
	logic [8:0]  cur_count;

	coord_result_t expected_results[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	logic stall_on;
	int unsigned stall_left = 0;

	network_coordinate_update u_dut (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [63:0] mag(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// floor(sqrt(a^2 + b^2)), digit by digit
	function automatic logic [63:0] hypot_floor(logic [63:0] a, logic [63:0] b);
		logic [127:0] s, rem, r, t;
		s = 128'(a) * 128'(a) + 128'(b) * 128'(b);
		rem = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | ((s >> (2 * i)) & 128'd3);
			t = (r << 2) | 128'd1;
			if (rem >= t) begin
				rem = rem - t;
				r = (r << 1) | 128'd1;
			end else begin
				r = r << 1;
			end
		end
		return r[63:0];
	endfunction

	function automatic longint moved(logic [63:0] unit, logic [63:0] sc, bit neg);
		logic [63:0] m;
		m = (unit * sc) >> 16;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// One spring pass against the given remote; updates the local state
	function automatic ncu_status_t spring_pass(longint rx, longint ry, longint rh,
			logic [63:0] rerr, logic [63:0] rt, sample_t s, inout logic fb);
		longint px, py, ph, re, vx, vy, vh, nx, ny, nh;
		logic [63:0] el, sum, w, dist_v, rt16, are, es, cw, ne, delta, sc, ux, uy, uh, m;
		bit neg, ok;
		px = longint'($signed(cur_x));
		py = longint'($signed(cur_y));
		ph = longint'($signed(cur_h));
		el = 64'(cur_err);
		if (mag(px) > k_maxc || mag(py) > k_maxc || mag(ph) > k_maxc ||
				mag(rx) > k_maxc || mag(ry) > k_maxc || mag(rh) > k_maxc)
			return STATUS_RANGE;
		if (rt == 0 || rt > k_maxrtt)
			return STATUS_RTT;
		sum = el + rerr;
		if (sum == 0)
			return STATUS_ERRSUM;
		w = (el << 16) / sum;
		dist_v = hypot_floor(mag(px - rx), mag(py - ry)) + mag(ph + rh);
		rt16 = rt << 4;
		re = longint'(rt16) - longint'(dist_v);
		are = mag(re);
		neg = re < 0;
		es = (are << 16) / rt16;
		if (es > M32) es = M32;
		cw = (k_egain * w) >> 16;
		ne = (es * cw + el * (64'd65536 - cw)) >> 16;
		if (ne > M32) ne = M32;
		delta = (k_cgain * w) >> 16;
		sc = (delta * are) >> 16;
		// direction away from the jittered remote, or the supplied one if degenerate
		vx = px - (rx + longint'(s.jx / 16'd10));
		vy = py - (ry + longint'(s.jy / 16'd10));
		vh = longint'(mag(ph + longint'(mag(rh))));
		m = hypot_floor(mag(vx), mag(vy)) + 64'(vh);
		if (m == 0) begin
			vx = longint'(s.dx);
			vy = longint'(s.dy);
			vh = longint'(s.dh);
			m = hypot_floor(64'(vx), 64'(vy)) + 64'(vh);
		end
		ok = m != 0;
		nx = px; ny = py; nh = ph;
		if (ok) begin
			ux = (mag(vx) << 16) / m;
			uy = (mag(vy) << 16) / m;
			uh = (64'(vh) << 16) / m;
			nx = px + moved(ux, sc, neg != (vx < 0));
			ny = py + moved(uy, sc, neg != (vy < 0));
			nh = longint'(mag(ph + moved(uh, sc, neg)));
			ok = mag(nx) <= k_maxc && mag(ny) <= k_maxc && mag(nh) <= k_maxc;
		end
		if (ok) begin
			cur_x = nx[31:0];
			cur_y = ny[31:0];
			cur_h = nh[31:0];
			cur_err = (ne > k_floor) ? ne[31:0] : k_floor[31:0];
		end else begin
			cur_x = '0; cur_y = '0; cur_h = '0;
			cur_err = k_init[31:0];
			fb = 1'b1;
		end
		return STATUS_OK;
	endfunction

	// Full step: measured pass, then a convergence pass when the count runs over
	function automatic coord_result_t predict_update(sample_t s);
		coord_result_t r;
		logic [8:0] cnt;
		r.fb = 1'b0;
		r.conv = 1'b0;
		r.status = spring_pass(longint'(s.rx), longint'(s.ry), longint'(s.rh),
			64'(s.rerr), 64'(s.rtt), s, r.fb);
		if (r.status == STATUS_OK) begin
			cnt = cur_count + ((s.rx != 0 || s.ry != 0) ? 9'd1 : 9'd0);
			if (64'(cnt) > k_every) begin
				cur_count = '0;
				r.conv = 1'b1;
				r.status = spring_pass(0, 0, 0, k_cerr, 64'(CONV_RTT), s, r.fb);
			end else begin
				cur_count = cnt;
			end
		end
		r.x = cur_x; r.y = cur_y; r.h = cur_h; r.err = cur_err;
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			CFG_COORD_GAIN:     k_cgain = 64'(val[15:0]);
			CFG_ERROR_GAIN:     k_egain = 64'(val[15:0]);
			CFG_ERROR_FLOOR:    k_floor = 64'(val);
			CFG_INITIAL_ERROR:  k_init = 64'(val);
			CFG_CONVERGE_EVERY: k_every = 64'(val[7:0]);
			CFG_CONVERGE_ERROR: k_cerr = 64'(val);
			CFG_MAX_COORDINATE: k_maxc = 64'(val[30:0]);
			default:            k_maxrtt = 64'(val);
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_all(logic [15:0] cg, logic [15:0] eg, logic [31:0] fl,
			logic [31:0] ie, logic [7:0] ev, logic [31:0] ce, logic [30:0] mc,
			logic [31:0] mr);
		write_reg(CFG_COORD_GAIN, 32'(cg));
		write_reg(CFG_ERROR_GAIN, 32'(eg));
		write_reg(CFG_ERROR_FLOOR, fl);
		write_reg(CFG_INITIAL_ERROR, ie);
		write_reg(CFG_CONVERGE_EVERY, 32'(ev));
		write_reg(CFG_CONVERGE_ERROR, ce);
		write_reg(CFG_MAX_COORDINATE, 32'(mc));
		write_reg(CFG_MAX_RTT, mr);
	endtask

	// Send one request; called just after a falling edge, returns at one
	task automatic send_sample(sample_t s);
		int unsigned gap;
		in_valid = 1'b1;
		remote_x = s.rx; remote_y = s.ry; remote_h = s.rh;
		remote_err = s.rerr; rtt = s.rtt;
		jitter_x = s.jx; jitter_y = s.jy;
		dir_x = s.dx; dir_y = s.dy; dir_h = s.dh;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(predict_update(s));
		@(negedge clk);
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 2);
		if (!stall_on) gap = 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Wait for every result, then let the block settle before touching config
	task automatic drain;
		in_valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic sample_t make_sample(logic signed [31:0] rx, logic signed [31:0] ry,
			logic signed [31:0] rh, logic [31:0] rerr, logic [31:0] rt);
		sample_t s;
		s.rx = rx; s.ry = ry; s.rh = rh; s.rerr = rerr; s.rtt = rt;
		s.jx = 16'($urandom); s.jy = 16'($urandom);
		s.dx = 16'($urandom); s.dy = 16'($urandom); s.dh = 16'($urandom);
		return s;
	endfunction

	// Plausible sample near the current local position, or pure noise
	function automatic sample_t random_sample(bit plausible);
		sample_t s;
		if (!plausible)
			return make_sample($urandom, $urandom, $urandom, $urandom, $urandom);
		s = make_sample($signed(cur_x) + $signed(32'($urandom_range(0, 1 << 24)) - (1 << 23)),
			$signed(cur_y) + $signed(32'($urandom_range(0, 1 << 24)) - (1 << 23)),
			$signed(32'($urandom_range(0, 1 << 22)) - (1 << 21)),
			$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1 << 10, 1 << 22),
			$urandom_range(1, 1 << 24));
		if ($urandom_range(0, 15) == 0) s.jx = '0;
		return s;
	endfunction

	// Fallback on an all-zero direction, a zero error sum, then a retry with the supplied direction
	task automatic test_zero_direction;
		sample_t s;
		write_reg(CFG_ERROR_FLOOR, 32'd0);
		write_reg(CFG_INITIAL_ERROR, 32'd0);
		s = make_sample(0, 0, 0, 32'd65536, 32'd4096);
		s.jx = '0; s.jy = '0; s.dx = '0; s.dy = '0; s.dh = '0;
		send_sample(s);
		send_sample(make_sample(0, 0, 0, 32'd0, 32'd4096));
		s = make_sample(0, 0, 0, 32'd65536, 32'd4096);
		s.jx = '0; s.jy = '0; s.dh = '0;
		send_sample(s);
		drain();
		write_reg(CFG_ERROR_FLOOR, 32'd6554);
		write_reg(CFG_INITIAL_ERROR, 32'd655360);
	endtask

	// Field extremes and the range and RTT rejection codes
	task automatic test_extremes;
		send_sample(make_sample(32'h8000_0000, 0, 0, 32'd65536, 32'd4096));
		send_sample(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, M32[31:0],
			M32[31:0]));
		send_sample(make_sample(100, 200, 0, 32'd65536, 32'd0));
		send_sample(make_sample(100, 200, 0, 32'd65536, 32'd1228800001));
		send_sample(make_sample(100, 200, 0, 32'd65536, 32'd1228800000));
		send_sample(make_sample(32'd1 << 20, -(32'd1 << 20), 32'd1 << 16, M32[31:0], 32'd1));
		send_sample(make_sample(-(32'd1 << 24), 32'd1 << 24, -(32'd1 << 18), 32'd0,
			32'h00FF_FFFF));
		send_sample(make_sample(32'd5 << 16, 32'd7 << 16, 0, 32'd1, 32'd1 << 20));
		drain();
	endtask

	// Convergence every update, gain extremes, huge errors
	task automatic test_gain_extremes;
		write_all(16'hFFFF, 16'hFFFF, 32'd0, M32[31:0], 8'd0, M32[31:0],
			31'h7FFF_FFFF, M32[31:0]);
		repeat (6) send_sample(random_sample(1'b1));
		send_sample(make_sample(32'd3 << 16, 32'd4 << 16, 0, M32[31:0], M32[31:0]));
		drain();
		write_all(16'd0, 16'd0, M32[31:0], 32'd0, 8'd255, 32'd0, 31'd1 << 30, 32'd1);
		repeat (4) send_sample(random_sample(1'b1));
		send_sample(make_sample(32'd1 << 16, 0, 0, 32'd100, 32'd1));
		drain();
	endtask

	// Lowering the bound under the current position rejects everything
	task automatic test_narrowed_bound;
		write_all(16'd16384, 16'd32768, 32'd6554, 32'd655360, 8'd5, 32'd3276800,
			31'd1966080000, 32'd1228800000);
		repeat (3) send_sample(random_sample(1'b1));
		drain();
		write_reg(CFG_MAX_COORDINATE, 32'd0);
		repeat (3) send_sample(random_sample(1'b1));
		drain();
		write_reg(CFG_MAX_COORDINATE, 32'd1966080000);
	endtask

	// Random traffic over several register settings
	task automatic test_random;
		logic [30:0] mc;
		logic [31:0] mr;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				mc = (phase == 5) ? 31'h7FFF_FFFF : 31'($urandom_range(1 << 26, 1 << 31));
				mr = (phase == 4) ? M32[31:0] : $urandom_range(1 << 20, 1 << 30);
				write_all(16'($urandom), 16'($urandom), $urandom_range(0, 1 << 18),
					$urandom_range(0, 1 << 22), 8'($urandom_range(0, 12)),
					$urandom, mc, mr);
			end
			stall_on = (phase != 2);
			repeat (80) send_sample(random_sample($urandom_range(0, 9) != 0));
			drain();
		end
		stall_on = 1'b1;
	endtask

	// Receiver stalls: mostly short, a few long
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (stall_on && $urandom_range(0, 3) == 0)
				stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(30, 150)
					: $urandom_range(1, 3);
		end
	end

	// Compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		coord_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: status %0d", status);
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status || local_x_out !== e.x || local_y_out !== e.y ||
						local_h_out !== e.h || local_err_out !== e.err ||
						fell_back !== e.fb || converged !== e.conv) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: exp %0d %h %h %h %h %b %b, got %0d %h %h %h %h %b %b",
							e.status, e.x, e.y, e.h, e.err, e.fb, e.conv, status,
							local_x_out, local_y_out, local_h_out, local_err_out,
							fell_back, converged);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		stall_on = 1'b1;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0;
		remote_x = '0; remote_y = '0; remote_h = '0; remote_err = '0; rtt = '0;
		jitter_x = '0; jitter_y = '0; dir_x = '0; dir_y = '0; dir_h = '0;
		k_cgain = 16384; k_egain = 32768; k_floor = 6554; k_init = 655360;
		k_every = 5; k_cerr = 3276800; k_maxc = 1966080000; k_maxrtt = 1228800000;
		cur_x = '0; cur_y = '0; cur_h = '0; cur_err = 32'd655360; cur_count = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_zero_direction();
		test_extremes();
		test_gain_extremes();
		test_narrowed_bound();
		test_random();
		drain();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ----- sim.f -----
design/ncu_pkg.sv
design/ncu_seq_unit.sv
design/network_coordinate_update.sv
design/ncu_checker.sv
tb/testbench.sv
